@@ rtl/core/l2pa_pkg.sv @@
// Shared types and constants for the log2 polynomial approximation block.
// Holds field widths, the Q4.28 coefficient table and the stage control struct.
// No dependencies.
`timescale 1ns / 1ps

package l2pa_pkg;

    // Operand layout
    localparam int FLOAT_W   = 32;
    localparam int FRAC_W    = 23;
    localparam int BEXP_W    = 8;
    localparam logic [BEXP_W-1:0] EXP_BIAS     = 8'd127;
    localparam logic [BEXP_W-1:0] EXP_BIAS_M1  = 8'd126;
    localparam logic [BEXP_W-1:0] EXP_ALL_ONES = 8'hFF;

    // Internal number formats
    localparam int MANT_W    = FRAC_W + 1;          // Q1.23 mantissa
    localparam int EXPO_W    = 7;                   // unsigned exponent magnitude
    localparam int COEF_W    = 32;                  // Q4.28 accumulator
    localparam int COEF_FRAC = 28;
    localparam int PROD_W    = COEF_W + MANT_W + 1;
    localparam int RES_W     = 34;                  // result before final truncation
    localparam int LOG_W     = 31;                  // log2_value width
    localparam int TDATA_W   = 32;

    // Reciprocal divider: quotient bits resolved per stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = MANT_W / DIV_STEP;
    localparam logic [MANT_W-1:0] REM_INIT = {1'b1, {FRAC_W{1'b0}}};

    // Horner evaluation
    localparam int HORNER_STEPS = 4;
    localparam logic signed [COEF_W-1:0] POLY_COEF [HORNER_STEPS+1] = '{
        -32'sd21908574,
         32'sd173179067,
        -32'sd569264361,
         32'sd1092556465,
        -32'sd674539109
    };

    // Unpack, divider, multiply/add pairs, finish, output register
    localparam int PIPE_DEPTH = 1 + DIV_STAGES + 2 * HORNER_STEPS + 1 + 1;

    typedef struct packed {
        logic              invalid;
        logic              below_one;
        logic              use_div;
        logic [EXPO_W-1:0] expo;
    } l2pa_ctl_t;

endpackage

@@ rtl/core/log2_poly_approximation_top.sv @@
// Top level of the approximate log2 block: unpack, reciprocal divider,
// Horner pipeline and output register. Depends on l2pa_pkg and the l2pa_* modules.
//
//  channel   | direction | tdata                              | tuser
//  s_axis    | in        | [31:0] float_bits                  | -
//  m_axis    | out       | [30:0] log2_value, [31] zero       | [0] invalid
//
// One transaction per cycle sustained while the output is not stalled.
// The pipeline runs through the unpack stage, the reciprocal divider (6 stages of 4 quotient bits),
// the four multiply/round-add pairs of the Horner chain, a finish stage and the output register.
// Every stage has its own valid bit; a stage loads when it is empty or its
// successor moves, so bubbles close up and a stalled output holds its transaction.
// Reset clears only the valid bits; there is no clearing pass.
`timescale 1ns / 1ps

module log2_poly_approximation_top #(
    parameter int OUT_FRAC_BITS = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] float_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] log2_value, [31] zero
    output logic [0:0]  m_axis_tuser    // [0] invalid
);
    import l2pa_pkg::*;

    logic                    up_valid;
    logic                    up_ready;
    l2pa_ctl_t               up_ctl;
    logic [MANT_W-1:0]       up_mant;
    logic                    dv_valid;
    logic                    dv_ready;
    l2pa_ctl_t               dv_ctl;
    logic [MANT_W-1:0]       dv_mant;
    logic                    hz_valid;
    logic                    hz_ready;
    l2pa_ctl_t               hz_ctl;
    logic signed [RES_W-1:0] hz_res;
    logic signed [RES_W-1:0] signed_res;

    logic                    out_valid_reg;
    logic [LOG_W-1:0]        value_reg;
    logic [LOG_W-1:0]        value_next;
    logic                    invalid_reg;

    l2pa_unpack u_unpack (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .float_bits (s_axis_tdata),
        .out_valid  (up_valid),
        .out_ready  (up_ready),
        .out_ctl    (up_ctl),
        .out_mant   (up_mant)
    );

    l2pa_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (up_valid),
        .in_ready  (up_ready),
        .in_ctl    (up_ctl),
        .in_mant   (up_mant),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_ctl   (dv_ctl),
        .out_mant  (dv_mant)
    );

    l2pa_horner #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_ctl    (dv_ctl),
        .in_mant   (dv_mant),
        .out_valid (hz_valid),
        .out_ready (hz_ready),
        .out_ctl   (hz_ctl),
        .out_res   (hz_res)
    );

    // Negate for operands below one, drop to zero for invalid operands
    assign signed_res = hz_ctl.below_one ? -hz_res : hz_res;
    assign value_next = hz_ctl.invalid ? '0 : signed_res[LOG_W-1:0];

    assign hz_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (hz_ready)
            out_valid_reg <= hz_valid;
    end

    always_ff @(posedge clk)
    begin
        if (hz_ready)
        begin
            value_reg   <= value_next;
            invalid_reg <= hz_ctl.invalid;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {{(TDATA_W - LOG_W){1'b0}}, value_reg};
    assign m_axis_tuser[0] = invalid_reg;

endmodule

@@ rtl/core/l2pa_unpack.sv @@
// Operand unpack stage: splits the float into exponent and mantissa and classifies it.
// Depends on l2pa_pkg.
`timescale 1ns / 1ps

module l2pa_unpack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [l2pa_pkg::FLOAT_W-1:0]    float_bits,
    output logic                            out_valid,
    input  logic                            out_ready,
    output l2pa_pkg::l2pa_ctl_t             out_ctl,
    output logic [l2pa_pkg::MANT_W-1:0]     out_mant
);
    import l2pa_pkg::*;

    logic                  valid_reg;
    l2pa_ctl_t             ctl_reg;
    l2pa_ctl_t             ctl_next;
    logic [MANT_W-1:0]     mant_reg;
    logic [BEXP_W-1:0]     bexp;
    logic [FRAC_W-1:0]     frac;
    logic [BEXP_W-1:0]     expo_wide;

    assign bexp = float_bits[FLOAT_W-2 -: BEXP_W];
    assign frac = float_bits[FRAC_W-1:0];

    // Classify the operand and pick the exponent magnitude
    always_comb
    begin
        ctl_next.invalid   = float_bits[FLOAT_W-1] || (bexp == '0) || (bexp == EXP_ALL_ONES);
        ctl_next.below_one = bexp < EXP_BIAS;
        ctl_next.use_div   = ctl_next.below_one && (frac != '0);
        if (!ctl_next.below_one)
            expo_wide = bexp - EXP_BIAS;
        else if (frac == '0)
            expo_wide = EXP_BIAS - bexp;
        else
            expo_wide = EXP_BIAS_M1 - bexp;
        ctl_next.expo = expo_wide[EXPO_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold the stage while downstream stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            ctl_reg  <= ctl_next;
            mant_reg <= {1'b1, frac};
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_mant  = mant_reg;

endmodule

@@ rtl/core/l2pa_recip.sv @@
// Pipelined reciprocal mantissa: round(2^47 / M) by restoring division,
// a few quotient bits per stage. Depends on l2pa_pkg.
`timescale 1ns / 1ps

module l2pa_recip (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  l2pa_pkg::l2pa_ctl_t             in_ctl,
    input  logic [l2pa_pkg::MANT_W-1:0]     in_mant,
    output logic                            out_valid,
    input  logic                            out_ready,
    output l2pa_pkg::l2pa_ctl_t             out_ctl,
    output logic [l2pa_pkg::MANT_W-1:0]     out_mant
);
    import l2pa_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES:0]   rdy;
    l2pa_ctl_t             ctl_reg [DIV_STAGES];
    logic [MANT_W-1:0]     m_reg   [DIV_STAGES];
    logic [MANT_W-1:0]     rem_reg [DIV_STAGES];
    logic [MANT_W-1:0]     quo_reg [DIV_STAGES];

    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready        = rdy[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic              v_in;
        l2pa_ctl_t         ctl_in;
        logic [MANT_W-1:0] m_in;
        logic [MANT_W-1:0] rem_in;
        logic [MANT_W-1:0] quo_in;
        logic [MANT_W-1:0] rem_next;
        logic [MANT_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign ctl_in = in_ctl;
            assign m_in   = in_mant;
            assign rem_in = REM_INIT;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign ctl_in = ctl_reg[k-1];
            assign m_in   = m_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Resolve DIV_STEP quotient bits; dividend low bits are M >> 1
        always_comb
        begin
            logic [MANT_W:0]   dvd;
            logic [MANT_W:0]   trial;
            logic [MANT_W-1:0] r;
            logic [MANT_W-1:0] q;
            dvd = {1'b0, m_in};
            r   = rem_in;
            q   = quo_in;
            for (int i = 0; i < DIV_STEP; i++)
            begin
                trial = {r, dvd[MANT_W - (k * DIV_STEP + i)]};
                if (trial >= {1'b0, m_in})
                begin
                    trial = trial - {1'b0, m_in};
                    q     = {q[MANT_W-2:0], 1'b1};
                end
                else
                begin
                    q     = {q[MANT_W-2:0], 1'b0};
                end
                r = trial[MANT_W-1:0];
            end
            rem_next = r;
            quo_next = q;
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (rdy[k])
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                ctl_reg[k] <= ctl_in;
                m_reg[k]   <= m_in;
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    // Pass the plain mantissa through when no reciprocal is needed
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_ctl   = ctl_reg[DIV_STAGES-1];
    assign out_mant  = ctl_reg[DIV_STAGES-1].use_div ? quo_reg[DIV_STAGES-1]
                                                     : m_reg[DIV_STAGES-1];

endmodule

@@ rtl/core/l2pa_horner.sv @@
// Pipelined quartic Horner evaluation in Q4.28 plus exponent add.
// Each step is a multiply stage followed by a round-and-add stage. Depends on l2pa_pkg.
`timescale 1ns / 1ps

module l2pa_horner #(
    parameter int OUT_FRAC_BITS = 22
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  l2pa_pkg::l2pa_ctl_t                 in_ctl,
    input  logic [l2pa_pkg::MANT_W-1:0]         in_mant,
    output logic                                out_valid,
    input  logic                                out_ready,
    output l2pa_pkg::l2pa_ctl_t                 out_ctl,
    output logic signed [l2pa_pkg::RES_W-1:0]   out_res
);
    import l2pa_pkg::*;

    localparam int RND_SHIFT = COEF_FRAC - OUT_FRAC_BITS;
    localparam logic signed [RES_W-1:0]  RND_HALF  = RES_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_W - 1);

    // Multiply stage registers
    logic [HORNER_STEPS-1:0]    mv_reg;
    logic signed [PROD_W-1:0]   prod_reg [HORNER_STEPS];
    logic [MANT_W-1:0]          pm_reg   [HORNER_STEPS];
    l2pa_ctl_t                  pc_reg   [HORNER_STEPS];
    // Round-and-add stage registers
    logic [HORNER_STEPS-1:0]    av_reg;
    logic signed [COEF_W-1:0]   acc_reg  [HORNER_STEPS];
    logic [MANT_W-1:0]          am_reg   [HORNER_STEPS];
    l2pa_ctl_t                  ac_reg   [HORNER_STEPS];
    // Finish stage registers
    logic                       fv_reg;
    l2pa_ctl_t                  fc_reg;
    logic signed [RES_W-1:0]    res_reg;
    logic signed [RES_W-1:0]    res_next;

    logic [HORNER_STEPS:0]      mrdy;
    logic [HORNER_STEPS-1:0]    ardy;
    logic                       frdy;

    assign frdy               = !fv_reg || out_ready;
    assign mrdy[HORNER_STEPS] = frdy;
    assign in_ready           = mrdy[0];

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_step
        logic                     v_in;
        l2pa_ctl_t                ctl_in;
        logic [MANT_W-1:0]        mant_in;
        logic signed [COEF_W-1:0] acc_in;
        logic signed [PROD_W-1:0] prod_next;
        logic signed [PROD_W-1:0] rounded;
        logic signed [COEF_W-1:0] acc_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign ctl_in  = in_ctl;
            assign mant_in = in_mant;
            assign acc_in  = POLY_COEF[0];
        end
        else
        begin : g_rest
            assign v_in    = av_reg[k-1];
            assign ctl_in  = ac_reg[k-1];
            assign mant_in = am_reg[k-1];
            assign acc_in  = acc_reg[k-1];
        end

        // Multiply accumulator by mantissa
        assign prod_next = acc_in * $signed({1'b0, mant_in});

        // Round product back to Q4.28, ties up, and add the next coefficient
        assign rounded  = (prod_reg[k] + PROD_HALF) >>> FRAC_W;
        assign acc_next = rounded[COEF_W-1:0] + POLY_COEF[k+1];

        assign mrdy[k] = !mv_reg[k] || ardy[k];
        assign ardy[k] = !av_reg[k] || mrdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg[k] <= 1'b0;
                av_reg[k] <= 1'b0;
            end
            else
            begin
                if (mrdy[k])
                    mv_reg[k] <= v_in;
                if (ardy[k])
                    av_reg[k] <= mv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (mrdy[k])
            begin
                prod_reg[k] <= prod_next;
                pm_reg[k]   <= mant_in;
                pc_reg[k]   <= ctl_in;
            end
            if (ardy[k])
            begin
                acc_reg[k] <= acc_next;
                am_reg[k]  <= pm_reg[k];
                ac_reg[k]  <= pc_reg[k];
            end
        end
    end

    // Round polynomial to output fraction bits and add the exponent
    assign res_next = ((RES_W'(acc_reg[HORNER_STEPS-1]) + RND_HALF) >>> RND_SHIFT)
                    + $signed(RES_W'(ac_reg[HORNER_STEPS-1].expo) << OUT_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (frdy)
            fv_reg <= av_reg[HORNER_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (frdy)
        begin
            fc_reg  <= ac_reg[HORNER_STEPS-1];
            res_reg <= res_next;
        end
    end

    assign out_valid = fv_reg;
    assign out_ctl   = fc_reg;
    assign out_res   = res_reg;

endmodule

@@ rtl/core/l2pa_checker.sv @@
// Port-level checker for the log2 block, bound to the top level.
// Tracks transactions in flight against the pipeline depth. Depends on l2pa_pkg.
`timescale 1ns / 1ps

module l2pa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);
    import l2pa_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Count transactions accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
            inflight_next = inflight_reg + 1'b1;
        else if (out_acc && !in_acc)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // No result without an accepted operand behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> !m_axis_tvalid)
        else $error("output valid with nothing in flight");

    // Never more in flight than the pipeline holds
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    // Invalid operands give a zero result
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid flag with nonzero result");

    // Stalled output holds its transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output changed");

endmodule

bind log2_poly_approximation_top l2pa_checker u_l2pa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/log2_poly_approximation_top_test.sv @@
// Self-checking testbench for log2_poly_approximation_top.
// Drives float operands over the input stream and checks each log2 result against
// an in-bench fixed-point predictor. Needs only the RTL of the block.
`timescale 1ns / 1ps

module log2_poly_approximation_top_test;

    localparam int OUT_FRAC    = 22;
    localparam int MANT_FRAC   = 23;
    localparam int COEF_FRAC   = 28;
    localparam int RAND_ITEMS  = 1926;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 15;
    localparam int QUIET_LO    = 900;      // no idling on either side in this window
    localparam int QUIET_HI    = 1200;
    localparam int HOLD_AT     = 400;      // long receiver hold-off starts here
    localparam int HOLD_CYCLES = 250;

    localparam logic [7:0]  BEXP_ONE   = 8'd127;
    localparam logic [7:0]  BEXP_SPCL  = 8'hFF;
    localparam logic [30:0] LOG_NONE   = 31'd0;
    localparam logic        FLAG_BAD   = 1'b1;
    localparam logic        FLAG_OK    = 1'b0;

    // Q4.28 quartic coefficients, highest power first
    localparam longint HORNER_COEF [5] = '{
        -64'sd21908574,
         64'sd173179067,
        -64'sd569264361,
         64'sd1092556465,
        -64'sd674539109
    };

    typedef struct packed {
        logic [31:0] operand;
        logic [30:0] log2_value;
        logic        invalid;
    } log2_result_t;

    typedef struct packed {
        logic [31:0] bits;
        logic        typed;      // expected result written in the row
        logic [30:0] log2_value;
        logic        invalid;
    } stim_row_t;

    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // invalid operands: zero, denormal, negative, infinite, NaN
        '{32'h0000_0000, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h8000_0000, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h0000_0001, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h007F_FFFF, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h7F80_0000, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'hFF80_0000, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h7FC0_0000, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h7F80_0001, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'hBF80_0000, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'hFFFF_FFFF, 1'b1, LOG_NONE, FLAG_BAD},
        '{32'h8080_0000, 1'b1, LOG_NONE, FLAG_BAD},
        // valid operands: around one, exponent extremes, exact powers of two
        '{32'h3F80_0000, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h3F7F_FFFF, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h3F80_0001, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h0080_0000, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h0080_0001, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h7F7F_FFFF, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h7F00_0000, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h3F00_0000, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h4000_0000, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h3FFF_FFFF, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h3EAA_AAAB, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h5A5A_5A5A, 1'b0, LOG_NONE, FLAG_OK},
        '{32'h25A5_A5A5, 1'b0, LOG_NONE, FLAG_OK}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] float_bits
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [30:0] log2_value, [31] zero
    logic [0:0]  m_axis_tuser;          // [0] invalid

    log2_result_t pending_logs [$];
    int n_sent     = 0;
    int n_recv     = 0;
    int n_invalid  = 0;
    int n_below    = 0;
    int n_errors   = 0;
    int n_cycles   = 0;

    log2_poly_approximation_top #(
        .OUT_FRAC_BITS(OUT_FRAC)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Arithmetic shift right by n, rounding to nearest with ties upward
    function automatic longint shift_round_up(longint v, int n);
        longint half;
        half = 64'sd1 <<< (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -(((-v) + half - 64'sd1) >>> n);
    endfunction

    // Expected log2 of one operand: exponent plus quartic of the Q1.23 mantissa
    function automatic log2_result_t predict_log2(logic [31:0] bits);
        logic [7:0]      bexp;
        logic [22:0]     frac;
        longint unsigned full_mant;
        longint unsigned mant;
        longint          expo;
        longint          acc;
        longint          res;
        bit              below;
        log2_result_t    r;
        bexp = bits[30:23];
        frac = bits[22:0];
        r.operand = bits;
        if (bits[31] || bexp == 8'd0 || bexp == BEXP_SPCL)
        begin
            r.log2_value = LOG_NONE;
            r.invalid    = FLAG_BAD;
            return r;
        end
        below     = bexp < BEXP_ONE;
        full_mant = (64'd1 << MANT_FRAC) | longint'(frac);
        if (!below)
        begin
            expo = longint'(bexp) - 127;
            mant = full_mant;
        end
        else if (frac == '0)
        begin
            expo = 127 - longint'(bexp);
            mant = 64'd1 << MANT_FRAC;
        end
        else
        begin
            // reciprocal mantissa 2/m, rounded to nearest
            expo = 126 - longint'(bexp);
            mant = ((64'd1 << 47) + (full_mant >> 1)) / full_mant;
        end
        acc = HORNER_COEF[0];
        for (int k = 1; k < 5; k++)
            acc = shift_round_up(acc * longint'(mant), MANT_FRAC) + HORNER_COEF[k];
        res = expo * (64'sd1 <<< OUT_FRAC) + shift_round_up(acc, COEF_FRAC - OUT_FRAC);
        if (below)
            res = -res;
        r.log2_value = res[30:0];
        r.invalid    = FLAG_OK;
        return r;
    endfunction

    // Mostly valid normals, weighted toward one and the exponent extremes
    function automatic logic [31:0] random_operand();
        int          pick;
        logic [7:0]  bexp;
        logic [22:0] frac;
        pick = $urandom_range(0, 99);
        frac = 23'($urandom());
        if ($urandom_range(0, 99) < 5)
            frac = '0;
        if (pick < 65)
            bexp = 8'($urandom_range(1, 254));
        else if (pick < 82)
            bexp = 8'($urandom_range(118, 136));
        else if (pick < 90)
        begin
            case ($urandom_range(0, 5))
                0:       bexp = 8'd1;
                1:       bexp = 8'd2;
                2:       bexp = BEXP_ONE - 8'd1;
                3:       bexp = BEXP_ONE;
                4:       bexp = 8'd253;
                default: bexp = 8'd254;
            endcase
        end
        else
            return $urandom();
        return {1'b0, bexp, frac};
    endfunction

    function automatic bit quiet_window(int count);
        return count >= QUIET_LO && count < QUIET_HI;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] operand,
                                   logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: operand %h got %h expected %h (result %0d)",
                 what, operand, got, want, n_recv);
        n_errors++;
    endtask

    // Offer one operand, idling first cycle by cycle at random;
    // record its expected result on acceptance
    task automatic offer_operand(logic [31:0] bits, bit typed, log2_result_t typed_res);
        if (!quiet_window(n_sent))
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
            pending_logs.push_back(typed_res);
        else
            pending_logs.push_back(predict_log2(bits));
        if (!bits[31] && bits[30:23] != 8'd0 && bits[30:23] < BEXP_ONE)
            n_below++;
        n_sent++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset, held low at start and then released
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Bound the run
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     n_cycles, pending_logs.size());
            $display("log2_poly_approximation_top test failed");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off, a quiet stretch
    initial
    begin : result_sink
        int  hold;
        bit  held_once;
        hold      = 0;
        held_once = 0;
        forever
        begin
            @(posedge clk);
            if (!held_once && n_recv >= HOLD_AT)
            begin
                held_once = 1;
                hold      = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (quiet_window(n_recv))
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        log2_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_recv++;
            if (pending_logs.size() == 0)
                report_mismatch("unexpected result", 32'hx, m_axis_tdata, 32'hx);
            else
            begin
                want = pending_logs.pop_front();
                if (want.invalid)
                    n_invalid++;
                if (m_axis_tdata[30:0] !== want.log2_value)
                    report_mismatch("log2_value", want.operand,
                                    {1'b0, m_axis_tdata[30:0]}, {1'b0, want.log2_value});
                if (m_axis_tdata[31] !== 1'b0)
                    report_mismatch("tdata pad bit", want.operand, m_axis_tdata, 32'd0);
                if (m_axis_tuser[0] !== want.invalid)
                    report_mismatch("invalid", want.operand,
                                    {31'd0, m_axis_tuser[0]}, {31'd0, want.invalid});
            end
        end
    end

    // Stimulus: directed table, then random operands, then drain
    initial
    begin : operand_source
        log2_result_t typed_res;
        while (rst_n !== 1'b1)
            @(posedge clk);
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            typed_res.operand    = DIRECTED[i].bits;
            typed_res.log2_value = DIRECTED[i].log2_value;
            typed_res.invalid    = DIRECTED[i].invalid;
            offer_operand(DIRECTED[i].bits, DIRECTED[i].typed, typed_res);
        end
        typed_res = '0;
        for (int i = 0; i < RAND_ITEMS; i++)
            offer_operand(random_operand(), 1'b0, typed_res);
        s_axis_tvalid <= 1'b0;
        while (pending_logs.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("Sent %0d operands (%0d directed), %0d below one, %0d flagged invalid",
                 n_sent, N_DIRECTED, n_below, n_invalid);
        $display("Checked %0d results with %0d mismatches in %0d cycles",
                 n_recv, n_errors, n_cycles);
        if (n_errors == 0)
            $display("log2_poly_approximation_top test passed");
        else
            $display("log2_poly_approximation_top test failed");
        $finish;
    end

endmodule
